[rtl/pfc_pkg.sv]
package pfc_pkg;

    // Letter codes: 0 is a, 25 is z.
    localparam int          ALPHA_SIZE  = 26;
    localparam int          SQ_CELLS    = 25;
    localparam logic [4:0]  LETTERS     = 5'd26;
    localparam logic [4:0]  LAST_LETTER = 5'd25;
    localparam logic [4:0]  LETTER_I    = 5'd8;
    localparam logic [4:0]  LETTER_J    = 5'd9;

    // Row and column coordinates of the 5x5 square.
    localparam logic [2:0]  LAST_IDX    = 3'd4;
    localparam logic [2:0]  FULL_ROW    = 3'd5;

    // Item modes.
    localparam logic [1:0]  MODE_KEY    = 2'd0;
    localparam logic [1:0]  MODE_FILL   = 2'd1;
    localparam logic [1:0]  MODE_ENC    = 2'd2;

    typedef logic [2:0] t_coord;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_rc;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] letter_first;
        logic [4:0] letter_second;
    } t_in_item;

    typedef struct packed {
        logic [4:0] cipher_first;
        logic [4:0] cipher_second;
        logic       status;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOK,
        ST_READ
    } t_state;

    typedef struct packed {
        logic key_step;
        logic fill_start;
        logic fill_step;
        logic enc_start;
        logic look;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic fill_last;
    } t_dp_stat;

    function automatic logic [4:0] fold_letter(input logic [4:0] letter);
        return (letter == LETTER_J) ? LETTER_I : letter;
    endfunction

    // Linear square position of a row and column: row * 5 + col.
    function automatic logic [4:0] rc_to_cell(input t_coord row, input t_coord col);
        logic [4:0] r5;
        r5 = {2'b00, row};
        return (r5 << 2) + r5 + {2'b00, col};
    endfunction

    function automatic t_coord wrap_inc(input t_coord c);
        return (c == LAST_IDX) ? 3'd0 : c + 3'd1;
    endfunction

endpackage

[rtl/playfair_pair_cipher_core.sv]
// Playfair pair cipher core. Each input item carries a mode. Mode 0 adds one
// key letter to the 5x5 square (j counts as i, repeats are skipped, and the
// first key letter after a completed square starts a fresh key); it gives
// no result. Mode 1 completes the square with the remaining letters in
// alphabetical order; it walks all 26 letter codes one per cycle, and the
// input stalls until the walk is done. Mode 2 enciphers a pair and gives
// one result item; an encrypt request before the square is complete, or
// with a letter code above 25, returns status 1 and zero letters. Each pair
// passes two registered memory reads in turn: the letter-to-position map,
// then the square itself; the result register is then loaded once it is
// free, and the next pair is taken in the same cycle. Mode 3 items are
// taken and dropped. The result sits in an output register, so the core
// accepts the next item while a result still waits to be taken.
module playfair_pair_cipher_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pfc_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pfc_pkg::t_out_item  o_out_item
);

    // Commands from the sequencer and status back from the datapath.
    pfc_pkg::t_dp_cmd  dp_cmd;
    pfc_pkg::t_dp_stat dp_stat;

    // The sequencer decodes the mode of each accepted item and steps the
    // square walk and the two-read encrypt flow.
    pfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_item.mode),
        .i_stat     (dp_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the square, the position map, the placed-letter
    // mask, the fill position and the result register.
    pfc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/pfc_ctrl.sv]
module pfc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_mode,
    input  pfc_pkg::t_dp_stat  i_stat,
    output logic               o_in_stall,
    output pfc_pkg::t_dp_cmd   o_cmd
);

    pfc_pkg::t_state r_state;
    pfc_pkg::t_state n_state;
    logic            can_take;
    logic            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        can_take = (r_state == pfc_pkg::ST_IDLE) ||
                   ((r_state == pfc_pkg::ST_READ) && i_stat.out_free);
        accept   = i_in_valid && can_take;

        unique case (r_state)
            pfc_pkg::ST_IDLE: begin
            end
            pfc_pkg::ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = pfc_pkg::ST_IDLE;
                end
            end
            pfc_pkg::ST_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = pfc_pkg::ST_READ;
            end
            pfc_pkg::ST_READ: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = pfc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfc_pkg::ST_IDLE;
            end
        endcase

        if (accept) begin
            unique case (i_mode)
                pfc_pkg::MODE_KEY: begin
                    o_cmd.key_step = 1'b1;
                end
                pfc_pkg::MODE_FILL: begin
                    o_cmd.fill_start = 1'b1;
                    n_state          = pfc_pkg::ST_FILL;
                end
                pfc_pkg::MODE_ENC: begin
                    o_cmd.enc_start = 1'b1;
                    n_state         = pfc_pkg::ST_LOOK;
                end
                default: begin
                end
            endcase
        end

        o_in_stall = !can_take;
    end

endmodule

[rtl/pfc_datapath.sv]
module pfc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfc_pkg::t_in_item   i_in_item,
    input  pfc_pkg::t_dp_cmd    i_cmd,
    input  logic                i_out_stall,
    output pfc_pkg::t_dp_stat   o_stat,
    output logic                o_out_valid,
    output pfc_pkg::t_out_item  o_out_item
);

    // Square contents by position, and the inverse map from letter to position.
    logic [4:0]      r_key_mem [pfc_pkg::SQ_CELLS];
    pfc_pkg::t_rc    r_pos_mem [pfc_pkg::ALPHA_SIZE];

    logic [pfc_pkg::ALPHA_SIZE-1:0] r_placed;
    logic [pfc_pkg::ALPHA_SIZE-1:0] n_placed;
    pfc_pkg::t_coord r_row, n_row, r_col, n_col;
    logic            r_complete, n_complete;
    logic [4:0]      r_fill_letter, n_fill_letter;
    logic            r_out_valid, n_out_valid;

    logic            r_err;
    pfc_pkg::t_rc    r_pos_a, r_pos_b;
    logic [4:0]      r_key_a, r_key_b;
    pfc_pkg::t_out_item r_out;

    logic [pfc_pkg::ALPHA_SIZE-1:0] base_map;
    pfc_pkg::t_coord base_row, base_col;
    logic            key_ok, clear_sq, place_req, place_go, out_taken;
    logic [4:0]      place_letter, place_cell, idx_a, idx_b;
    logic            a_ok, b_ok;
    pfc_pkg::t_coord oa_row, oa_col, ob_row, ob_col;

    always_comb begin
        key_ok   = i_cmd.key_step && (i_in_item.letter_first < pfc_pkg::LETTERS);
        clear_sq = key_ok && r_complete;
        base_map = clear_sq ? '0 : r_placed;
        base_row = clear_sq ? 3'd0 : r_row;
        base_col = clear_sq ? 3'd0 : r_col;

        place_letter = i_cmd.fill_step ? r_fill_letter
                                       : pfc_pkg::fold_letter(i_in_item.letter_first);
        place_req    = key_ok ||
                       (i_cmd.fill_step && (r_fill_letter != pfc_pkg::LETTER_J));
        place_go     = place_req && !base_map[place_letter] &&
                       (base_row != pfc_pkg::FULL_ROW);
        place_cell   = pfc_pkg::rc_to_cell(base_row, base_col);

        n_placed = base_map;
        n_row    = base_row;
        n_col    = base_col;
        if (place_go) begin
            n_placed[place_letter] = 1'b1;
            n_col = pfc_pkg::wrap_inc(base_col);
            if (base_col == pfc_pkg::LAST_IDX) begin
                n_row = base_row + 3'd1;
            end
        end

        n_complete = r_complete;
        if (clear_sq) begin
            n_complete = 1'b0;
        end
        if (i_cmd.fill_step && (r_fill_letter == pfc_pkg::LAST_LETTER)) begin
            n_complete = 1'b1;
        end

        n_fill_letter = r_fill_letter;
        if (i_cmd.fill_start) begin
            n_fill_letter = '0;
        end else if (i_cmd.fill_step) begin
            n_fill_letter = r_fill_letter + 5'd1;
        end

        out_taken   = r_out_valid && !i_out_stall;
        n_out_valid = i_cmd.load_out ? 1'b1 : (out_taken ? 1'b0 : r_out_valid);

        a_ok  = i_in_item.letter_first < pfc_pkg::LETTERS;
        b_ok  = i_in_item.letter_second < pfc_pkg::LETTERS;
        idx_a = a_ok ? pfc_pkg::fold_letter(i_in_item.letter_first) : 5'd0;
        idx_b = b_ok ? pfc_pkg::fold_letter(i_in_item.letter_second) : 5'd0;

        // Row rule, column rule, otherwise swap the columns of the rectangle.
        if (r_pos_a.row == r_pos_b.row) begin
            oa_row = r_pos_a.row;
            oa_col = pfc_pkg::wrap_inc(r_pos_a.col);
            ob_row = r_pos_b.row;
            ob_col = pfc_pkg::wrap_inc(r_pos_b.col);
        end else if (r_pos_a.col == r_pos_b.col) begin
            oa_row = pfc_pkg::wrap_inc(r_pos_a.row);
            oa_col = r_pos_a.col;
            ob_row = pfc_pkg::wrap_inc(r_pos_b.row);
            ob_col = r_pos_b.col;
        end else begin
            oa_row = r_pos_a.row;
            oa_col = r_pos_b.col;
            ob_row = r_pos_b.row;
            ob_col = r_pos_a.col;
        end

        o_stat.out_free  = !r_out_valid || !i_out_stall;
        o_stat.fill_last = (r_fill_letter == pfc_pkg::LAST_LETTER);
    end

    always_ff @(posedge i_clk) begin
        if (place_go) begin
            r_key_mem[place_cell]   <= place_letter;
            r_pos_mem[place_letter] <= '{row: base_row, col: base_col};
        end
        if (i_cmd.enc_start) begin
            r_err   <= !r_complete || !a_ok || !b_ok;
            r_pos_a <= r_pos_mem[idx_a];
            r_pos_b <= r_pos_mem[idx_b];
        end
        if (i_cmd.look) begin
            r_key_a <= r_key_mem[pfc_pkg::rc_to_cell(oa_row, oa_col)];
            r_key_b <= r_key_mem[pfc_pkg::rc_to_cell(ob_row, ob_col)];
        end
        if (i_cmd.load_out) begin
            if (r_err) begin
                r_out <= '{cipher_first: 5'd0, cipher_second: 5'd0, status: 1'b1};
            end else begin
                r_out <= '{cipher_first: r_key_a, cipher_second: r_key_b, status: 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_placed      <= '0;
            r_row         <= '0;
            r_col         <= '0;
            r_complete    <= 1'b0;
            r_fill_letter <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_placed      <= n_placed;
            r_row         <= n_row;
            r_col         <= n_col;
            r_complete    <= n_complete;
            r_fill_letter <= n_fill_letter;
            r_out_valid   <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_complete_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> (r_row == pfc_pkg::FULL_ROW))
        else $error("square marked complete but not full");

    a_no_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_placed[pfc_pkg::LETTER_J])
        else $error("letter j placed in the square");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_placed) == int'(pfc_pkg::rc_to_cell(r_row, r_col)))
        else $error("placed letters disagree with fill position");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && i_out_stall))
        else $error("result register loaded while holding a stalled item");
`endif

endmodule

[tb/playfair_pair_cipher_checker.sv]
module playfair_pair_cipher_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  pfc_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  pfc_pkg::t_out_item i_out_item,
    output int                 o_mismatches,
    output int                 o_pending
);

    localparam int SIDE = 5;

    // Shadow copy of the key square and its bookkeeping.
    logic [4:0]                     square [0:pfc_pkg::SQ_CELLS-1];
    logic [pfc_pkg::ALPHA_SIZE-1:0] placed;
    int                             filled;
    logic                           square_done;
    pfc_pkg::t_out_item             due_ciphers [$];

    function automatic void place(input logic [4:0] letter);
        if (!placed[letter] && filled < pfc_pkg::SQ_CELLS) begin
            square[filled] = letter;
            placed[letter] = 1'b1;
            filled++;
        end
    endfunction

    function automatic int cell_of(input logic [4:0] letter);
        for (int p = 0; p < pfc_pkg::SQ_CELLS; p++) begin
            if (square[p] == letter) begin
                return p;
            end
        end
        return 0;
    endfunction

    function automatic void advance_square(input pfc_pkg::t_in_item it);
        logic [4:0]         a;
        logic [4:0]         b;
        int                 pa, pb, ra, ca, rb, cb, oa, ob;
        pfc_pkg::t_out_item res;
        a = it.letter_first;
        b = it.letter_second;
        case (it.mode)
            pfc_pkg::MODE_KEY: begin
                if (a < pfc_pkg::LETTERS) begin
                    // The first key letter after completion starts a new key.
                    if (square_done) begin
                        placed      = '0;
                        filled      = 0;
                        square_done = 1'b0;
                    end
                    place((a == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : a);
                end
            end
            pfc_pkg::MODE_FILL: begin
                for (int l = 0; l < pfc_pkg::ALPHA_SIZE; l++) begin
                    if (l != pfc_pkg::LETTER_J) begin
                        place(l[4:0]);
                    end
                end
                square_done = 1'b1;
            end
            pfc_pkg::MODE_ENC: begin
                res = '0;
                if (!square_done || a >= pfc_pkg::LETTERS || b >= pfc_pkg::LETTERS) begin
                    res.status = 1'b1;
                end else begin
                    pa = cell_of((a == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : a);
                    pb = cell_of((b == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : b);
                    ra = pa / SIDE;
                    ca = pa % SIDE;
                    rb = pb / SIDE;
                    cb = pb % SIDE;
                    if (ra == rb) begin
                        oa = ra * SIDE + (ca + 1) % SIDE;
                        ob = rb * SIDE + (cb + 1) % SIDE;
                    end else if (ca == cb) begin
                        oa = ((ra + 1) % SIDE) * SIDE + ca;
                        ob = ((rb + 1) % SIDE) * SIDE + cb;
                    end else begin
                        oa = ra * SIDE + cb;
                        ob = rb * SIDE + ca;
                    end
                    res.cipher_first  = square[oa];
                    res.cipher_second = square[ob];
                end
                due_ciphers.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [4:0] want,
                                        input logic [4:0] got);
        if (got !== want) begin
            o_mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        pfc_pkg::t_out_item want;
        if (!i_rst_n) begin
            placed      = '0;
            filled      = 0;
            square_done = 1'b0;
            due_ciphers.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_ciphers.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: expected no item, got %0d %0d status %0d", $time,
                             i_out_item.cipher_first, i_out_item.cipher_second,
                             i_out_item.status);
                end else begin
                    want = due_ciphers.pop_front();
                    check_field("cipher_first", want.cipher_first, i_out_item.cipher_first);
                    check_field("cipher_second", want.cipher_second,
                                i_out_item.cipher_second);
                    check_field("status", {4'd0, want.status}, {4'd0, i_out_item.status});
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_square(i_in_item);
            end
        end
        o_pending = due_ciphers.size();
    end

endmodule

[tb/tb_playfair_pair_cipher_core.sv]
module tb_playfair_pair_cipher_core;

    // Stimulus stops after this many accepted items; the last stretch of them
    // runs with neither side idling so that back-to-back traffic is covered.
    localparam int ITEMS        = 1400;
    localparam int TAIL_ITEMS   = 200;
    // Cycles to wait after the last expected item, enough for a stray result
    // or a square completion walk to show up.
    localparam int DRAIN_CYCLES = 40;
    // The limit allows for the worst case per item (fill walk, gaps, stalls).
    localparam int CYCLE_LIMIT  = 400000;
    // Mode 3 has no name in the package; the core takes and drops it.
    localparam logic [1:0] MODE_VOID = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    pfc_pkg::t_in_item  in_item;
    logic               out_valid;
    logic               out_stall;
    pfc_pkg::t_out_item out_item;

    int   items_sent;
    int   stall_left;
    int   cycles;
    int   mismatches;
    int   pending;
    logic quiet_tail;

    // items_sent only changes right after a rising edge, so this is stable
    // whenever it is looked at on a falling edge.
    assign quiet_tail = (items_sent >= ITEMS - TAIL_ITEMS);

    playfair_pair_cipher_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    playfair_pair_cipher_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: the stall comes in random bursts, with calm stretches in
    // between and none at all in the final part of the run.
    always @(negedge clk) begin
        if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5);
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("playfair_pair_cipher_core: mismatch");
            $finish;
        end
    end

    // Offers one item from a falling edge and holds it, unchanged, until the
    // core takes it. An idle burst may come first. Returns on the falling edge
    // after the accepting rising edge, with valid still high, so that the next
    // item follows without a gap unless one is chosen.
    task automatic send_item(input logic [1:0] mode, input logic [4:0] first,
                             input logic [4:0] second);
        pfc_pkg::t_in_item it;
        it.mode          = mode;
        it.letter_first  = first;
        it.letter_second = second;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
        @(negedge clk);
    endtask

    initial begin
        int perm [0:pfc_pkg::ALPHA_SIZE-1];
        int pick;
        int swap;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        out_stall  = 1'b0;
        items_sent = 0;
        stall_left = 0;
        cycles     = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. An encrypt before any square exists must fail with
        // status 1, and a mode 3 item with every letter bit set is dropped.
        send_item(pfc_pkg::MODE_ENC, 5'd2, 5'd3);
        send_item(MODE_VOID, 5'd31, 5'd31);
        // Key letters above z are ignored.
        send_item(pfc_pkg::MODE_KEY, 5'd31, 5'd0);
        send_item(pfc_pkg::MODE_KEY, pfc_pkg::LETTERS, 5'd31);
        // Key "playjiaz": j folds into i, so the repeated i and the repeated
        // a are skipped. Square rows become:
        //   p l a y i / z b c d e / f g h k m / n o q r s / t u v w x
        send_item(pfc_pkg::MODE_KEY, 5'd15, 5'd0);
        send_item(pfc_pkg::MODE_KEY, 5'd11, 5'd25);
        send_item(pfc_pkg::MODE_KEY, 5'd0, 5'd0);
        send_item(pfc_pkg::MODE_KEY, 5'd24, 5'd0);
        send_item(pfc_pkg::MODE_KEY, pfc_pkg::LETTER_J, 5'd0);
        send_item(pfc_pkg::MODE_KEY, pfc_pkg::LETTER_I, 5'd0);
        send_item(pfc_pkg::MODE_KEY, 5'd0, 5'd0);
        send_item(pfc_pkg::MODE_KEY, pfc_pkg::LAST_LETTER, 5'd0);
        // Complete the square twice; the second pass finds nothing to add.
        send_item(pfc_pkg::MODE_FILL, 5'd21, 5'd10);
        send_item(pfc_pkg::MODE_FILL, 5'd0, 5'd31);
        // Same row (p, y), same column (l, g), rectangle (a, e), identical
        // letters (c, c), j in a pair (j, z), and a column wrapping from the
        // bottom row back to the top (i, x).
        send_item(pfc_pkg::MODE_ENC, 5'd15, 5'd24);
        send_item(pfc_pkg::MODE_ENC, 5'd11, 5'd6);
        send_item(pfc_pkg::MODE_ENC, 5'd0, 5'd4);
        send_item(pfc_pkg::MODE_ENC, 5'd2, 5'd2);
        send_item(pfc_pkg::MODE_ENC, pfc_pkg::LETTER_J, pfc_pkg::LAST_LETTER);
        send_item(pfc_pkg::MODE_ENC, pfc_pkg::LETTER_I, 5'd23);
        // Letters out of range in either slot give status 1.
        send_item(pfc_pkg::MODE_ENC, 5'd0, 5'd31);
        send_item(pfc_pkg::MODE_ENC, 5'd30, pfc_pkg::LAST_LETTER);
        // A key letter after completion starts a new key, so the square is
        // incomplete again and encrypting fails.
        send_item(pfc_pkg::MODE_KEY, pfc_pkg::LAST_LETTER, 5'd17);
        send_item(pfc_pkg::MODE_ENC, 5'd4, 5'd12);

        // Random part. Most rounds are well formed: a key of random length,
        // a completion, then a batch of pairs. Noise is mixed in: key letters
        // out of range, encrypts before completion, double completions, mode
        // 3 items and pairs with a letter out of range. Now and then the key
        // covers the whole alphabet so the square is filled by key letters.
        while (items_sent < ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                for (int k = 0; k < pfc_pkg::ALPHA_SIZE; k++) begin
                    perm[k] = k;
                end
                for (int k = pfc_pkg::ALPHA_SIZE - 1; k > 0; k--) begin
                    pick       = $urandom_range(0, k);
                    swap       = perm[k];
                    perm[k]    = perm[pick];
                    perm[pick] = swap;
                end
                for (int k = 0; k < pfc_pkg::ALPHA_SIZE; k++) begin
                    send_item(pfc_pkg::MODE_KEY, 5'(perm[k]), 5'($urandom_range(0, 31)));
                end
            end else begin
                repeat ($urandom_range(0, 12)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(pfc_pkg::MODE_KEY,
                                  5'($urandom_range(pfc_pkg::LETTERS, 31)),
                                  5'($urandom_range(0, 31)));
                    end else begin
                        send_item(pfc_pkg::MODE_KEY,
                                  5'($urandom_range(0, pfc_pkg::LAST_LETTER)),
                                  5'($urandom_range(0, 31)));
                    end
                end
            end
            if ($urandom_range(0, 5) == 0) begin
                send_item(pfc_pkg::MODE_ENC, 5'($urandom_range(0, pfc_pkg::LAST_LETTER)),
                          5'($urandom_range(0, pfc_pkg::LAST_LETTER)));
            end
            send_item(pfc_pkg::MODE_FILL, 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)));
            if ($urandom_range(0, 7) == 0) begin
                send_item(pfc_pkg::MODE_FILL, 5'($urandom_range(0, 31)),
                          5'($urandom_range(0, 31)));
            end
            repeat ($urandom_range(4, 40)) begin
                case ($urandom_range(0, 19))
                    0: send_item(MODE_VOID, 5'($urandom_range(0, 31)),
                                 5'($urandom_range(0, 31)));
                    1: send_item(pfc_pkg::MODE_ENC,
                                 5'($urandom_range(pfc_pkg::LETTERS, 31)),
                                 5'($urandom_range(0, 31)));
                    2: send_item(pfc_pkg::MODE_ENC,
                                 5'($urandom_range(0, pfc_pkg::LAST_LETTER)),
                                 5'($urandom_range(pfc_pkg::LETTERS, 31)));
                    default: send_item(pfc_pkg::MODE_ENC,
                                       5'($urandom_range(0, pfc_pkg::LAST_LETTER)),
                                       5'($urandom_range(0, pfc_pkg::LAST_LETTER)));
                endcase
            end
        end
        in_valid <= 1'b0;

        // Drain: wait for every expected item, then a little longer so that
        // any extra result from the core is still caught by the checker.
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0) begin
            $display("playfair_pair_cipher_core: match");
        end else begin
            $display("playfair_pair_cipher_core: mismatch");
        end
        $finish;
    end

endmodule
